FILE: design/dart_keyboard_channel_defines.svh
// assertion macros for the dart keyboard channel
// used by dart_keyboard_channel.sv; no other dependencies
`ifndef DART_KEYBOARD_CHANNEL_DEFINES_SVH
`define DART_KEYBOARD_CHANNEL_DEFINES_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define DKC_ASSERT_NOW(label, clock, rst_n, ante, cons) \
	label: assert property (@(posedge clock) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("dkc assertion failed");
// next-cycle implication
`define DKC_ASSERT_NEXT(label, clock, rst_n, ante, cons) \
	label: assert property (@(posedge clock) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("dkc assertion failed");
`else
`define DKC_ASSERT_NOW(label, clock, rst_n, ante, cons)
`define DKC_ASSERT_NEXT(label, clock, rst_n, ante, cons)
`endif
`endif

FILE: design/dkc_pkg.sv
// shared types and constants for the dart keyboard channel
// no dependencies
`default_nettype none
package dkc_pkg;

	typedef enum logic [2:0] {
		OP_WRITE   = 3'd0,
		OP_READ    = 3'd1,
		OP_VSYNC   = 3'd2,
		OP_KEY_DN  = 3'd3,
		OP_KEY_UP  = 3'd4
	} op_t;

	localparam logic PORT_DATA = 1'b0;
	localparam logic PORT_CTRL = 1'b1;

	localparam logic [2:0] REG_STATUS = 3'd0;
	localparam logic [2:0] REG_INTCTL = 3'd1;
	localparam logic [2:0] REG_VECTOR = 3'd2;
	localparam logic [2:0] REG_MODE   = 3'd5;

	localparam logic [2:0] CMD_VSYNC_LATCH = 3'd2;
	localparam logic [2:0] CMD_CHAN_RESET  = 3'd3;

	localparam logic [7:0] KEY_RESET_VAL  = 8'hff;
	localparam logic [7:0] REG1_READ_VAL  = 8'h01;
	localparam logic [7:0] VEC_EN_MASK    = 8'h18;
	localparam logic [7:0] VEC_STATUS_BIT = 8'h04;
	localparam logic [7:0] VEC_HI_MASK    = 8'hf0;
	localparam logic [7:0] VEC_FIX_MASK   = 8'hfe;
	localparam logic [7:0] STATUS_FIXED   = 8'h24;

	typedef struct packed {
		logic [2:0] reg_pointer;
		logic [7:0] ctl_reg1;
		logic [7:0] ctl_reg2;
		logic       mode40_flag;
		logic       mem_flag;
		logic       vsync_pending;
		logic       vsync_latched;
		logic [7:0] key_value;
		logic       key_new;
		logic       key_down;
	} state_t;

	typedef struct packed {
		logic [7:0] rdata;
		logic       vector_enabled;
		logic [7:0] irq_vector;
		logic       mode40;
		logic       mem_select;
		logic       irq_request;
	} result_t;

endpackage
`default_nettype wire

FILE: design/dart_keyboard_channel.sv
// top level of the dart keyboard channel: input register, state, result register
// depends on dkc_pkg, dkc_core and dart_keyboard_channel_defines.svh
//
//  channel   signals                               direction
//  request   req_valid req_stall op port_sel        in (stall out)
//            wdata key_code
//  result    res_valid res_stall rdata              out (stall in)
//            vector_enabled irq_vector mode40
//            mem_select irq_request
//
// one request per cycle unless the result is stalled; a taken request is held in
// the input register, and the state is updated as it moves on to the result register
// while the result is stalled one more request is held in the input register
// reset clears all channel state and both valid flags; key code resets to all ones
`default_nettype none
`include "dart_keyboard_channel_defines.svh"
module dart_keyboard_channel (
	input  wire  logic       clk,
	input  wire  logic       arst_n,
	input  wire  logic       req_valid,
	output logic             req_stall,
	input  wire  logic [2:0] op,
	input  wire  logic       port_sel,
	input  wire  logic [7:0] wdata,
	input  wire  logic [7:0] key_code,
	output logic             res_valid,
	input  wire  logic       res_stall,
	output logic [7:0]       rdata,
	output logic             vector_enabled,
	output logic [7:0]       irq_vector,
	output logic             mode40,
	output logic             mem_select,
	output logic             irq_request
);
	import dkc_pkg::*;

	logic       valid_s1;
	logic [2:0] op_s1;
	logic       port_sel_s1;
	logic [7:0] wdata_s1;
	logic [7:0] key_code_s1;

	state_t  state_q;
	state_t  state_nxt;
	result_t res_nxt;
	result_t res_q;
	logic    res_valid_q;

	logic advance;
	logic take;

	assign advance   = valid_s1 && (!res_valid_q || !res_stall);
	assign req_stall = valid_s1 && !advance;
	assign take      = req_valid && !req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			op_s1       <= op;
			port_sel_s1 <= port_sel;
			wdata_s1    <= wdata;
			key_code_s1 <= key_code;
		end
	end

	dkc_core u_core (
		.cur      (state_q),
		.op       (op_s1),
		.port_sel (port_sel_s1),
		.wdata    (wdata_s1),
		.key_code (key_code_s1),
		.nxt      (state_nxt),
		.res      (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q               <= '{key_value: KEY_RESET_VAL, default: '0};
			res_valid_q           <= 1'b0;
		end else begin
			if (advance) begin
				state_q <= state_nxt;
			end
			if (advance) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_nxt;
		end
	end

	assign res_valid      = res_valid_q;
	assign rdata          = res_q.rdata;
	assign vector_enabled = res_q.vector_enabled;
	assign irq_vector     = res_q.irq_vector;
	assign mode40         = res_q.mode40;
	assign mem_select     = res_q.mem_select;
	assign irq_request    = res_q.irq_request;

	`DKC_ASSERT_NOW(a_vec_off_zero, clk, arst_n, res_valid && !vector_enabled, irq_vector == 8'h00)
	`DKC_ASSERT_NOW(a_irq_no_rdata, clk, arst_n, res_valid && irq_request, rdata == 8'h00)
	`DKC_ASSERT_NEXT(a_ctrl_read_ptr, clk, arst_n, advance && (op_s1 == OP_READ) && (port_sel_s1 == PORT_CTRL), state_q.reg_pointer == 3'd0)
	`DKC_ASSERT_NEXT(a_key_press_new, clk, arst_n, advance && (op_s1 == OP_KEY_DN), state_q.key_new && state_q.key_down)

endmodule
`default_nettype wire

FILE: design/dkc_core.sv
// next-state and result logic for one request of the keyboard channel
// depends on dkc_pkg
`default_nettype none
module dkc_core (
	input  wire dkc_pkg::state_t  cur,
	input  wire logic [2:0]       op,
	input  wire logic             port_sel,
	input  wire logic [7:0]       wdata,
	input  wire logic [7:0]       key_code,
	output dkc_pkg::state_t       nxt,
	output dkc_pkg::result_t      res
);
	import dkc_pkg::*;

	logic [7:0] rd;
	logic       irq;

	always_comb begin
		nxt = cur;
		rd  = '0;
		irq = 1'b0;
		unique case (op)
			OP_WRITE: begin
				if (port_sel == PORT_CTRL) begin
					nxt.reg_pointer = '0;
					unique case (cur.reg_pointer)
						REG_STATUS: begin
							nxt.reg_pointer = wdata[2:0];
							unique case (wdata[5:3])
								CMD_VSYNC_LATCH: begin
									nxt.vsync_latched = cur.vsync_pending;
									nxt.vsync_pending = 1'b0;
								end
								CMD_CHAN_RESET: begin
									nxt.reg_pointer = '0;
									nxt.ctl_reg1    = '0;
									nxt.ctl_reg2    = '0;
								end
								default: ;
							endcase
						end
						REG_INTCTL: nxt.ctl_reg1 = wdata;
						REG_VECTOR: nxt.ctl_reg2 = wdata;
						REG_MODE: begin
							nxt.mode40_flag = wdata[1];
							nxt.mem_flag    = wdata[7];
						end
						default: ;
					endcase
				end
			end
			OP_READ: begin
				if (port_sel == PORT_DATA) begin
					rd          = cur.key_value;
					nxt.key_new = 1'b0;
				end else begin
					nxt.reg_pointer = '0;
					unique case (cur.reg_pointer)
						REG_STATUS: rd = STATUS_FIXED | {3'b000, cur.vsync_latched,
							cur.key_down, 2'b00, cur.key_new};
						REG_INTCTL: rd = REG1_READ_VAL;
						REG_VECTOR: rd = cur.ctl_reg2;
						default:    rd = '0;
					endcase
				end
			end
			OP_VSYNC: nxt.vsync_pending = 1'b1;
			OP_KEY_DN: begin
				nxt.key_value = key_code;
				nxt.key_new   = 1'b1;
				nxt.key_down  = 1'b1;
				irq           = 1'b1;
			end
			OP_KEY_UP: nxt.key_down = 1'b0;
			default: ;
		endcase
	end

	// vector follows the updated control registers
	always_comb begin
		res.rdata          = rd;
		res.irq_request    = irq;
		res.mode40         = nxt.mode40_flag;
		res.mem_select     = nxt.mem_flag;
		res.vector_enabled = (nxt.ctl_reg1 & VEC_EN_MASK) != 8'h00;
		if (!res.vector_enabled)
			res.irq_vector = '0;
		else if ((nxt.ctl_reg1 & VEC_STATUS_BIT) != 8'h00)
			res.irq_vector = (nxt.ctl_reg2 & VEC_HI_MASK) | VEC_STATUS_BIT;
		else
			res.irq_vector = nxt.ctl_reg2 & VEC_FIX_MASK;
	end

endmodule
`default_nettype wire

FILE: sim/dart_keyboard_channel_tb.sv
// self-checking testbench for the dart keyboard channel: directed register, key and vsync
// tests, then random bus traffic checked against a cycle-free model of the channel state
// depends on dkc_pkg and dart_keyboard_channel
module dart_keyboard_channel_tb;
	import dkc_pkg::*;

	localparam logic [2:0] OP_UNUSED_LO = 3'd5;
	localparam logic [2:0] OP_UNUSED_HI = 3'd7;
	localparam logic [2:0] CMD_NONE     = 3'd0;
	localparam int         QUIET_LIMIT  = 500;
	localparam int         DRAIN_CYCLES = 20;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       req_valid = 1'b0;
	logic       req_stall;
	logic [2:0] op = OP_WRITE;
	logic       port_sel = PORT_DATA;
	logic [7:0] wdata = 8'h00;
	logic [7:0] key_code = 8'h00;
	logic       res_valid;
	logic       res_stall = 1'b0;
	logic [7:0] rdata;
	logic       vector_enabled;
	logic [7:0] irq_vector;
	logic       mode40;
	logic       mem_select;
	logic       irq_request;

	state_t  chan;
	result_t chan_results_q[$];
	result_t want;
	int      errors = 0;
	int      requests_sent = 0;
	int      results_checked = 0;
	int      chan_resets = 0;
	int      vsync_latches = 0;
	int      key_presses = 0;
	int      quiet_cycles = 0;
	int      stall_left = 0;
	bit      src_idle_on = 1'b0;
	bit      sink_idle_on = 1'b0;

	dart_keyboard_channel dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.op(op),
		.port_sel(port_sel),
		.wdata(wdata),
		.key_code(key_code),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.rdata(rdata),
		.vector_enabled(vector_enabled),
		.irq_vector(irq_vector),
		.mode40(mode40),
		.mem_select(mem_select),
		.irq_request(irq_request)
	);

	always #6 clk = ~clk;

	function automatic void reset_channel_model();
		chan = '0;
		chan.key_value = KEY_RESET_VAL;
	endfunction

	// applies one request to the channel state and returns what the bus should see
	function automatic result_t predict_channel(logic [2:0] o, logic p, logic [7:0] w,
			logic [7:0] k);
		result_t res;
		logic [2:0] idx;
		res = '0;
		case (o)
			OP_WRITE: begin
				if (p == PORT_CTRL) begin
					idx = chan.reg_pointer;
					chan.reg_pointer = REG_STATUS;
					case (idx)
						REG_STATUS: begin
							chan.reg_pointer = w[2:0];
							if (w[5:3] == CMD_VSYNC_LATCH) begin
								chan.vsync_latched = chan.vsync_pending;
								chan.vsync_pending = 1'b0;
								vsync_latches++;
							end else if (w[5:3] == CMD_CHAN_RESET) begin
								chan.reg_pointer = REG_STATUS;
								chan.ctl_reg1 = '0;
								chan.ctl_reg2 = '0;
								chan_resets++;
							end
						end
						REG_INTCTL: chan.ctl_reg1 = w;
						REG_VECTOR: chan.ctl_reg2 = w;
						REG_MODE: begin
							chan.mode40_flag = w[1];
							chan.mem_flag = w[7];
						end
						default: ;
					endcase
				end
			end
			OP_READ: begin
				if (p == PORT_DATA) begin
					res.rdata = chan.key_value;
					chan.key_new = 1'b0;
				end else begin
					idx = chan.reg_pointer;
					chan.reg_pointer = REG_STATUS;
					case (idx)
						REG_STATUS: begin
							res.rdata = STATUS_FIXED;
							res.rdata[0] = chan.key_new;
							res.rdata[3] = chan.key_down;
							res.rdata[4] = chan.vsync_latched;
						end
						REG_INTCTL: res.rdata = REG1_READ_VAL;
						REG_VECTOR: res.rdata = chan.ctl_reg2;
						default: res.rdata = '0;
					endcase
				end
			end
			OP_VSYNC: chan.vsync_pending = 1'b1;
			OP_KEY_DN: begin
				chan.key_value = k;
				chan.key_new = 1'b1;
				chan.key_down = 1'b1;
				res.irq_request = 1'b1;
				key_presses++;
			end
			OP_KEY_UP: chan.key_down = 1'b0;
			default: ;
		endcase
		if ((chan.ctl_reg1 & VEC_EN_MASK) != '0) begin
			res.vector_enabled = 1'b1;
			if ((chan.ctl_reg1 & VEC_STATUS_BIT) != '0)
				res.irq_vector = (chan.ctl_reg2 & VEC_HI_MASK) | VEC_STATUS_BIT;
			else
				res.irq_vector = chan.ctl_reg2 & VEC_FIX_MASK;
		end
		res.mode40 = chan.mode40_flag;
		res.mem_select = chan.mem_flag;
		return res;
	endfunction

	function automatic logic [7:0] ptr_byte(logic [2:0] cmd, logic [2:0] idx);
		return {2'b00, cmd, idx};
	endfunction

	// drives one request and holds it until taken, then maybe leaves a gap
	task automatic send_req(input logic [2:0] o, input logic p, input logic [7:0] w,
			input logic [7:0] k);
		req_valid <= 1'b1;
		op <= o;
		port_sel <= p;
		wdata <= w;
		key_code <= k;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		chan_results_q.push_back(predict_channel(o, p, w, k));
		requests_sent++;
		if (src_idle_on && $urandom_range(0, 3) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	task automatic check_field(input string name, input logic [7:0] exp_v,
			input logic [7:0] got_v);
		if (exp_v !== got_v) begin
			$display("%0t: %s expected %02h got %02h", $time, name, exp_v, got_v);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			if (chan_results_q.size() == 0) begin
				$display("%0t: result with no request outstanding, rdata %02h", $time, rdata);
				errors++;
			end else begin
				want = chan_results_q.pop_front();
				check_field("rdata", want.rdata, rdata);
				check_field("vector_enabled", 8'(want.vector_enabled), 8'(vector_enabled));
				check_field("irq_vector", want.irq_vector, irq_vector);
				check_field("mode40", 8'(want.mode40), 8'(mode40));
				check_field("mem_select", 8'(want.mem_select), 8'(mem_select));
				check_field("irq_request", 8'(want.irq_request), 8'(irq_request));
				results_checked++;
			end
		end
	end

	// result side backpressure in random bursts, applied only while sink idling is on
	always @(posedge clk) begin
		if (!sink_idle_on) begin
			res_stall <= 1'b0;
		end else if (stall_left != 0) begin
			res_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 5) == 0) begin
			res_stall <= 1'b1;
			stall_left <= $urandom_range(0, 11);
		end else begin
			res_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (res_valid && !res_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == QUIET_LIMIT) begin
			$display("%0t: no request or result moved for %0d cycles", $time, QUIET_LIMIT);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic test_reset_state();
		send_req(OP_READ, PORT_CTRL, 8'h00, 8'h00);
		send_req(OP_READ, PORT_DATA, 8'h00, 8'h00);
	endtask

	task automatic test_key_events();
		send_req(OP_KEY_DN, PORT_DATA, 8'h00, 8'h00);
		send_req(OP_READ, PORT_CTRL, 8'h00, 8'h00);
		send_req(OP_READ, PORT_DATA, 8'h00, 8'h00);
		send_req(OP_KEY_UP, PORT_DATA, 8'h00, 8'h00);
		send_req(OP_KEY_DN, PORT_CTRL, 8'hff, 8'hff);
	endtask

	task automatic test_vsync_latch();
		send_req(OP_VSYNC, PORT_CTRL, 8'h00, 8'h00);
		send_req(OP_WRITE, PORT_CTRL, ptr_byte(CMD_VSYNC_LATCH, REG_STATUS), 8'h00);
		send_req(OP_READ, PORT_CTRL, 8'h00, 8'h00);
	endtask

	task automatic test_vector_and_mode();
		send_req(OP_WRITE, PORT_CTRL, ptr_byte(CMD_NONE, REG_INTCTL), 8'h00);
		send_req(OP_WRITE, PORT_CTRL, 8'h1c, 8'h00);
		send_req(OP_WRITE, PORT_CTRL, ptr_byte(CMD_NONE, REG_VECTOR), 8'h00);
		send_req(OP_WRITE, PORT_CTRL, 8'hff, 8'h00);
		send_req(OP_WRITE, PORT_CTRL, ptr_byte(CMD_NONE, REG_INTCTL), 8'h00);
		send_req(OP_WRITE, PORT_CTRL, 8'h08, 8'h00);
		send_req(OP_WRITE, PORT_CTRL, ptr_byte(CMD_NONE, REG_MODE), 8'h00);
		send_req(OP_WRITE, PORT_CTRL, 8'h82, 8'h00);
		send_req(OP_WRITE, PORT_DATA, 8'hff, 8'h00);
		send_req(OP_WRITE, PORT_CTRL, ptr_byte(CMD_NONE, REG_VECTOR), 8'h00);
		send_req(OP_READ, PORT_CTRL, 8'h00, 8'h00);
	endtask

	task automatic test_channel_reset();
		// command also carries a pointer, which the reset must override
		send_req(OP_WRITE, PORT_CTRL, ptr_byte(CMD_CHAN_RESET, REG_MODE), 8'h00);
		send_req(OP_READ, PORT_CTRL, 8'h00, 8'h00);
	endtask

	task automatic test_unused_ops();
		int u;
		for (u = OP_UNUSED_LO; u <= OP_UNUSED_HI; u++)
			send_req(3'(u), PORT_CTRL, 8'hff, 8'hff);
	endtask

	// pointer load followed by an access of the selected register, or a single event
	task automatic send_random_item();
		logic [7:0] b;
		logic [2:0] idx;
		int pick;
		int sel;
		pick = $urandom_range(0, 99);
		if (pick < 40) begin
			b = 8'($urandom_range(0, 255));
			sel = $urandom_range(0, 99);
			if (sel < 20)
				b[5:3] = CMD_VSYNC_LATCH;
			else if (sel < 28)
				b[5:3] = CMD_CHAN_RESET;
			else if (sel < 70)
				b[5:3] = CMD_NONE;
			idx = 3'($urandom_range(0, 7));
			sel = $urandom_range(0, 9);
			b[2:0] = (sel < 3) ? REG_INTCTL : (sel < 6) ? REG_VECTOR : (sel < 8) ? REG_MODE : idx;
			send_req(OP_WRITE, PORT_CTRL, b, 8'($urandom_range(0, 255)));
			if ($urandom_range(0, 9) < 6)
				send_req(OP_WRITE, PORT_CTRL, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
			else
				send_req(OP_READ, PORT_CTRL, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
		end else if (pick < 52) begin
			send_req(OP_KEY_DN, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
				8'($urandom_range(0, 255)));
		end else if (pick < 60) begin
			send_req(OP_KEY_UP, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
				8'($urandom_range(0, 255)));
		end else if (pick < 70) begin
			send_req(OP_VSYNC, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
				8'($urandom_range(0, 255)));
		end else if (pick < 95) begin
			send_req(OP_READ, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
				8'($urandom_range(0, 255)));
		end else if (pick < 98) begin
			send_req(OP_WRITE, PORT_DATA, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
		end else begin
			send_req(3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI)), 1'($urandom_range(0, 1)),
				8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
		end
	endtask

	task automatic test_random_traffic(input int n);
		int stop_at;
		int next_switch;
		stop_at = requests_sent + n;
		next_switch = requests_sent;
		while (requests_sent < stop_at) begin
			if (requests_sent >= next_switch) begin
				// idling on or off per stretch so some stretches run flat out
				src_idle_on = ($urandom_range(0, 3) != 0);
				sink_idle_on = ($urandom_range(0, 3) != 0);
				next_switch = requests_sent + 100;
			end
			send_random_item();
		end
	endtask

	task automatic test_random_no_idle(input int n);
		int stop_at;
		stop_at = requests_sent + n;
		src_idle_on = 1'b0;
		sink_idle_on = 1'b0;
		while (requests_sent < stop_at)
			send_random_item();
	endtask

	initial begin
		reset_channel_model();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		src_idle_on = 1'b1;
		sink_idle_on = 1'b1;
		test_reset_state();
		test_key_events();
		test_vsync_latch();
		test_vector_and_mode();
		test_channel_reset();
		test_unused_ops();
		test_random_traffic(1200);
		test_random_no_idle(300);
		req_valid <= 1'b0;
		while (chan_results_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("covered %0d requests, %0d results checked", requests_sent, results_checked);
		$display("seen %0d key presses, %0d vsync latch commands, %0d channel resets",
			key_presses, vsync_latches, chan_resets);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
